// ===== hdl/arp_icmp_udp_frame_responder_assert.svh =====
// ----------------------------------------------------------------------------
// arp_icmp_udp_frame_responder assertion macros
// concurrent checks clocked on clk_i, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ARP_ICMP_UDP_FRAME_RESPONDER_ASSERT_SVH
`define ARP_ICMP_UDP_FRAME_RESPONDER_ASSERT_SVH

`ifndef SYNTH
// checked outside reset
`define AIUFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aiufr assertion failed");
// checked on every edge, reset included
`define AIUFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("aiufr assertion failed");
`else
`define AIUFR_ASSERT(lbl, prop)
`define AIUFR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/aiufr_pkg.sv =====
// ----------------------------------------------------------------------------
// aiufr_pkg
// shared types and constants of the frame responder
// ----------------------------------------------------------------------------
`default_nettype none

package aiufr_pkg;

  localparam int FRAME_BYTES = 2048;
  localparam int LED_BYTES   = 484;
  localparam int AW          = $clog2(FRAME_BYTES);
  localparam int CW          = AW + 1;
  localparam int HDR_BYTES   = 42;
  localparam int HW          = $clog2(HDR_BYTES);

  localparam logic [15:0] ETH_ARP     = 16'h0806;
  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [15:0] ARP_REQUEST = 16'h0001;
  localparam logic [7:0]  ARP_REPLY   = 8'h02;
  localparam logic [7:0]  PROTO_ICMP  = 8'h01;
  localparam logic [7:0]  PROTO_UDP   = 8'h11;
  localparam logic [7:0]  ICMP_ECHO   = 8'h08;
  localparam logic [15:0] LED_PORT_LO = 16'd50000;
  localparam logic [15:0] LED_PORT_HI = 16'd50003;
  localparam logic [7:0]  LED_MARK    = 8'h80;
  localparam logic [11:0] ARP_MIN_LEN = 12'd42;
  localparam logic [11:0] ICMP_MIN_LEN = 12'd38;

  localparam logic CFG_MY_IP  = 1'b0;
  localparam logic CFG_MY_MAC = 1'b1;

  typedef enum logic [1:0] {
    VERD_DROP = 2'd0,
    VERD_ARP  = 2'd1,
    VERD_ECHO = 2'd2,
    VERD_LED  = 2'd3
  } verdict_e;

  typedef struct packed {
    logic        action;
    logic [7:0]  data;
    logic        last;
    logic [10:0] index;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  verdict;
    logic [1:0]  led_channel;
    logic [11:0] length;
    logic        truncated;
    logic [7:0]  byte_out;
  } res_t;

  typedef struct packed {
    logic          clr_we;
    logic          rcv;
    logic          rd_issue;
    logic          hdr_rd;
    logic          hdr_shift;
    logic          decide;
    logic          wb_we;
    logic          emit_read;
    logic [AW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic rewrite;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/aiufr_ram.sv =====
// ----------------------------------------------------------------------------
// aiufr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module aiufr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/aiufr_dp.sv =====
// ----------------------------------------------------------------------------
// aiufr_dp
// frame store, header capture, verdict logic, reply rewrite and read-out
// ----------------------------------------------------------------------------
`default_nettype none

module aiufr_dp
  import aiufr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire req_t        req_i,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  output res_t             res_o
);

  logic [31:0]   my_ip_q;
  logic [47:0]   my_mac_q;
  logic [CW-1:0] wc_q, wc_d;
  logic          cut_now_q, cut_now_d;
  logic          cut_last_q, cut_last_d;
  logic [11:0]   flen_q, flen_d;
  verdict_e      verd_q, verd_d;
  logic [1:0]    chan_q, chan_d;
  logic [10:0]   idx_q;
  logic          oob_q;
  logic [7:0]    hdr_q [HDR_BYTES];
  logic [7:0]    nh [HDR_BYTES];

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [11:0]   rd_full;
  logic          full;

  verdict_e      new_verd;
  logic [1:0]    new_chan;
  logic [15:0]   eth_type;
  logic [15:0]   udp_port;
  logic [16:0]   cs_sum, cs_f1, cs_f2;
  logic [15:0]   cs_new;
  logic [11:0]   len_out;
  logic [7:0]    byte_rd;
  logic [HW-1:0] hstep;

  assign full  = (wc_q >= CW'(FRAME_BYTES));
  assign hstep = cmd_i.step[HW-1:0];

  aiufr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // led reads start at the udp payload
  always_comb begin
    if (verd_q == VERD_LED) begin
      rd_full = 12'(HDR_BYTES) + {1'b0, req_i.index};
    end else begin
      rd_full = {1'b0, req_i.index};
    end
  end

  always_comb begin
    ram_raddr = cmd_i.hdr_rd ? cmd_i.step : rd_full[AW-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd_i.step;
    ram_wdata = '0;
    if (cmd_i.clr_we) begin
      ram_we = 1'b1;
    end else if (cmd_i.rcv && !full) begin
      ram_we    = 1'b1;
      ram_waddr = wc_q[AW-1:0];
      ram_wdata = req_i.data;
    end else if (cmd_i.wb_we) begin
      ram_we    = 1'b1;
      ram_wdata = nh[hstep];
    end
  end

  // verdict from the captured header
  always_comb begin
    eth_type = {hdr_q[12], hdr_q[13]};
    udp_port = {hdr_q[36], hdr_q[37]};
    new_verd = VERD_DROP;
    new_chan = 2'd0;
    if (eth_type == ETH_ARP) begin
      if (flen_q >= ARP_MIN_LEN && {hdr_q[20], hdr_q[21]} == ARP_REQUEST &&
          {hdr_q[38], hdr_q[39], hdr_q[40], hdr_q[41]} == my_ip_q) begin
        new_verd = VERD_ARP;
      end
    end else if (eth_type == ETH_IPV4) begin
      if (hdr_q[23] == PROTO_ICMP) begin
        if (flen_q >= ICMP_MIN_LEN && hdr_q[34] == ICMP_ECHO &&
            {hdr_q[30], hdr_q[31], hdr_q[32], hdr_q[33]} == my_ip_q) begin
          new_verd = VERD_ECHO;
        end
      end else if (hdr_q[23] == PROTO_UDP) begin
        if (flen_q >= ARP_MIN_LEN && udp_port >= LED_PORT_LO &&
            udp_port <= LED_PORT_HI) begin
          new_verd = VERD_LED;
          new_chan = udp_port[1:0] - LED_PORT_LO[1:0];
        end
      end
    end
  end

  assign stat_o.rewrite = (new_verd == VERD_ARP) || (new_verd == VERD_ECHO);

  // incremental checksum: type word drops by 0x0800
  always_comb begin
    cs_sum = {1'b0, ~{hdr_q[36], hdr_q[37]}} + 17'h0F7FF;
    cs_f1  = {1'b0, cs_sum[15:0]} + {16'd0, cs_sum[16]};
    cs_f2  = {1'b0, cs_f1[15:0]} + {16'd0, cs_f1[16]};
    cs_new = ~cs_f2[15:0];
  end

  always_comb begin
    for (int k = 0; k < HDR_BYTES; k++) begin
      nh[k] = hdr_q[k];
    end
    for (int k = 0; k < 6; k++) begin
      nh[k]     = hdr_q[6 + k];
      nh[6 + k] = my_mac_q[8*(5-k) +: 8];
    end
    if (verd_q == VERD_ARP) begin
      nh[20] = 8'h00;
      nh[21] = ARP_REPLY;
      for (int k = 0; k < 6; k++) begin
        nh[32 + k] = hdr_q[22 + k];
        nh[22 + k] = my_mac_q[8*(5-k) +: 8];
      end
      for (int k = 0; k < 4; k++) begin
        nh[38 + k] = hdr_q[28 + k];
        nh[28 + k] = my_ip_q[8*(3-k) +: 8];
      end
    end else begin
      nh[34] = 8'h00;
      nh[36] = cs_new[15:8];
      nh[37] = cs_new[7:0];
      for (int k = 0; k < 4; k++) begin
        nh[30 + k] = hdr_q[26 + k];
        nh[26 + k] = my_ip_q[8*(3-k) +: 8];
      end
    end
  end

  always_comb begin
    wc_d       = wc_q;
    cut_now_d  = cut_now_q;
    cut_last_d = cut_last_q;
    flen_d     = flen_q;
    verd_d     = verd_q;
    chan_d     = chan_q;
    if (cmd_i.rcv) begin
      if (!full) begin
        wc_d = wc_q + 1'b1;
      end else begin
        cut_now_d = 1'b1;
      end
      if (req_i.last) begin
        flen_d     = 12'(wc_d);
        cut_last_d = cut_now_d;
        wc_d       = '0;
        cut_now_d  = 1'b0;
      end
    end
    if (cmd_i.decide) begin
      verd_d = new_verd;
      chan_d = new_chan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_ip_q    <= '0;
      my_mac_q   <= '0;
      wc_q       <= '0;
      cut_now_q  <= 1'b0;
      cut_last_q <= 1'b0;
      flen_q     <= '0;
      verd_q     <= VERD_DROP;
      chan_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i[0] == CFG_MY_IP) begin
          my_ip_q <= cfg_data_i[31:0];
        end else begin
          my_mac_q <= cfg_data_i;
        end
      end
      wc_q       <= wc_d;
      cut_now_q  <= cut_now_d;
      cut_last_q <= cut_last_d;
      flen_q     <= flen_d;
      verd_q     <= verd_d;
      chan_q     <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      idx_q <= req_i.index;
      oob_q <= (rd_full >= 12'(FRAME_BYTES));
    end
    if (cmd_i.hdr_shift) begin
      for (int k = 0; k < HDR_BYTES - 1; k++) begin
        hdr_q[k] <= hdr_q[k + 1];
      end
      hdr_q[HDR_BYTES-1] <= ram_rdata;
    end
  end

  always_comb begin
    case (verd_q)
      VERD_LED:  len_out = 12'(LED_BYTES + 1);
      VERD_DROP: len_out = 12'd0;
      default:   len_out = flen_q;
    endcase
  end

  always_comb begin
    byte_rd = 8'd0;
    if (verd_q != VERD_DROP && {1'b0, idx_q} < len_out) begin
      if (verd_q == VERD_LED) begin
        if (idx_q < 11'(LED_BYTES)) begin
          byte_rd = (oob_q ? 8'd0 : ram_rdata) | LED_MARK;
        end
      end else begin
        byte_rd = ram_rdata;
      end
    end
  end

  always_comb begin
    res_o.kind        = cmd_i.emit_read;
    res_o.verdict     = verd_q;
    res_o.led_channel = chan_q;
    res_o.length      = len_out;
    res_o.truncated   = cut_last_q;
    res_o.byte_out    = cmd_i.emit_read ? byte_rd : 8'd0;
  end

endmodule

`default_nettype wire

// ===== hdl/aiufr_ctrl.sv =====
// ----------------------------------------------------------------------------
// aiufr_ctrl
// sequencer: store clearing, header capture, reply rewrite and result timing
// ----------------------------------------------------------------------------
`default_nettype none

`include "arp_icmp_udp_frame_responder_assert.svh"

module aiufr_ctrl
  import aiufr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  input  wire logic  action_i,
  input  wire logic  last_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o,
  output logic       busy,
  output logic       res_valid_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HDR,
    ST_DECIDE,
    ST_WB,
    ST_REPORT,
    ST_READ
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          take;

  assign take = start && (state_q == ST_IDLE);

  always_comb begin
    cmd_o.clr_we    = (state_q == ST_CLEAR);
    cmd_o.rcv       = take && !action_i;
    cmd_o.rd_issue  = take && action_i;
    cmd_o.hdr_rd    = (state_q == ST_HDR) && (cnt_q < AW'(HDR_BYTES));
    cmd_o.hdr_shift = (state_q == ST_HDR) && (cnt_q != '0);
    cmd_o.decide    = (state_q == ST_DECIDE);
    cmd_o.wb_we     = (state_q == ST_WB);
    cmd_o.emit_read = (state_q == ST_READ);
    cmd_o.step      = cnt_q;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_REPORT) || (state_q == ST_READ);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AW'(FRAME_BYTES - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      ST_IDLE: begin
        if (take && action_i) begin
          state_d = ST_READ;
        end else if (take && last_i) begin
          state_d = ST_HDR;
          cnt_d   = '0;
        end
      end
      ST_HDR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AW'(HDR_BYTES)) begin
          state_d = ST_DECIDE;
          cnt_d   = '0;
        end
      end
      ST_DECIDE: begin
        state_d = stat_i.rewrite ? ST_WB : ST_REPORT;
      end
      ST_WB: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == AW'(HDR_BYTES - 1)) begin
          state_d = ST_REPORT;
          cnt_d   = '0;
        end
      end
      ST_REPORT: state_d = ST_IDLE;
      ST_READ:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `AIUFR_ASSERT(a_read_answers, (start && !busy && action_i) |=> res_valid_o)
  `AIUFR_ASSERT(a_last_starts_capture,
      (start && !busy && !action_i && last_i) |=> (cmd_o.hdr_rd && cmd_o.step == '0))
  `AIUFR_ASSERT_ALWAYS(a_rewrite_only_replies, cmd_o.wb_we |-> stat_i.rewrite)

endmodule

`default_nettype wire

// ===== hdl/arp_icmp_udp_frame_responder.sv =====
// ----------------------------------------------------------------------------
// arp_icmp_udp_frame_responder
// stores an ethernet frame and answers arp requests, pings and led udp data
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A receive request
// (action 0) writes one frame byte in the same cycle, unless the store is
// full, and busy stays low unless the byte is flagged last, so frame bytes
// may arrive one per cycle until the last one. The byte flagged last starts
// the verdict: ST_HDR reads the first 42 header bytes out of the store,
// ST_DECIDE decides, and for arp and echo replies ST_WB writes the rewritten
// header back, one store write per cycle. The verdict result then shows for
// one cycle with res_valid_o. A read request (action 1) gives its result in
// the next cycle, from the registered read port of the frame store; busy is
// high while that result shows, so the next request is taken after it.
// Results cannot be held off; each is valid for exactly one cycle.
// After reset the frame store is cleared, one byte a cycle, with busy high;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_icmp_udp_frame_responder
  import aiufr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req_i,
  output res_t             res_o,
  output logic             res_valid_o
);

  cmd_t  cmd;
  stat_t stat;

  aiufr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .action_i    (req_i.action),
    .last_i      (req_i.last),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy),
    .res_valid_o (res_valid_o)
  );

  aiufr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives frames and read requests into the frame responder and checks every
// verdict and read byte against an in-bench model of the responder or a table
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import aiufr_pkg::*;

  typedef struct {
    req_t r;
    bit   typed;
    res_t e;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = CFG_MY_IP;
  logic [47:0] cfg_data_i = '0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  res_t        res_o;
  logic        res_valid_o;

  // model state
  logic [7:0]  mdl_store [FRAME_BYTES];
  int          mdl_wcount;
  int          mdl_flen;
  verdict_e    mdl_verd;
  logic [1:0]  mdl_chan;
  bit          mdl_cut_now, mdl_cut_last;
  logic [31:0] mdl_ip;
  logic [47:0] mdl_mac;

  res_t        pending_res [$];
  int          errors = 0;
  int          n_items = 0;
  logic [7:0]  frame_buf [$];

  arp_icmp_udp_frame_responder dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .start(start), .busy(busy), .req_i(req_i),
    .res_o(res_o), .res_valid_o(res_valid_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("arp_icmp_udp_frame_responder test failed");
    $finish;
  end

  function automatic logic [7:0] st_rd(int i);
    return (i < FRAME_BYTES) ? mdl_store[i] : 8'h00;
  endfunction

  function automatic void st_wr(int i, logic [7:0] v);
    if (i < FRAME_BYTES) mdl_store[i] = v;
  endfunction

  function automatic logic [15:0] st_rd16(int i);
    return {st_rd(i), st_rd(i + 1)};
  endfunction

  function automatic logic [31:0] st_rd32(int i);
    return {st_rd16(i), st_rd16(i + 2)};
  endfunction

  function automatic logic [7:0] mac_at(int k);
    return mdl_mac[40 - 8*k +: 8];
  endfunction

  function automatic logic [7:0] ip_at(int k);
    return mdl_ip[24 - 8*k +: 8];
  endfunction

  function automatic void swap_eth();
    for (int k = 0; k < 6; k++) begin
      st_wr(k, st_rd(6 + k));
      st_wr(6 + k, mac_at(k));
    end
  endfunction

  function automatic verdict_e judge_frame();
    logic [15:0] etype;
    logic [16:0] sum;
    logic [15:0] port;
    etype = st_rd16(12);
    mdl_chan = 2'd0;
    if (etype == ETH_ARP) begin
      if (mdl_flen < ARP_MIN_LEN || st_rd16(20) != ARP_REQUEST || st_rd32(38) != mdl_ip)
        return VERD_DROP;
      st_wr(20, 8'h00);
      st_wr(21, ARP_REPLY);
      for (int k = 0; k < 6; k++) begin
        st_wr(32 + k, st_rd(22 + k));
        st_wr(22 + k, mac_at(k));
      end
      for (int k = 0; k < 4; k++) begin
        st_wr(38 + k, st_rd(28 + k));
        st_wr(28 + k, ip_at(k));
      end
      swap_eth();
      return VERD_ARP;
    end
    if (etype != ETH_IPV4) return VERD_DROP;
    if (st_rd(23) == PROTO_ICMP) begin
      if (mdl_flen < ICMP_MIN_LEN || st_rd32(30) != mdl_ip || st_rd(34) != ICMP_ECHO)
        return VERD_DROP;
      st_wr(34, 8'h00);
      // one's complement update, type word drops by 0x0800
      sum = {1'b0, ~st_rd16(36)} + 17'h0F7FF;
      sum = {1'b0, sum[15:0]} + sum[16];
      sum = {1'b0, sum[15:0]} + sum[16];
      st_wr(36, ~sum[15:8]);
      st_wr(37, ~sum[7:0]);
      for (int k = 0; k < 4; k++) begin
        st_wr(30 + k, st_rd(26 + k));
        st_wr(26 + k, ip_at(k));
      end
      swap_eth();
      return VERD_ECHO;
    end
    if (st_rd(23) == PROTO_UDP) begin
      port = st_rd16(36);
      if (mdl_flen < ARP_MIN_LEN || port < LED_PORT_LO || port > LED_PORT_HI)
        return VERD_DROP;
      mdl_chan = 2'(port - LED_PORT_LO);
      return VERD_LED;
    end
    return VERD_DROP;
  endfunction

  function automatic int reply_len();
    if (mdl_verd == VERD_LED) return LED_BYTES + 1;
    if (mdl_verd == VERD_DROP) return 0;
    return mdl_flen;
  endfunction

  function automatic bit respond(req_t r, output res_t e);
    logic [7:0] b;
    int idx;
    b = 8'h00;
    idx = r.index;
    if (r.action == 1'b0) begin
      if (mdl_wcount < FRAME_BYTES) begin
        mdl_store[mdl_wcount] = r.data;
        mdl_wcount++;
      end else begin
        mdl_cut_now = 1'b1;
      end
      if (!r.last) return 1'b0;
      mdl_flen = mdl_wcount;
      mdl_cut_last = mdl_cut_now;
      mdl_wcount = 0;
      mdl_cut_now = 1'b0;
      mdl_verd = judge_frame();
    end else if (mdl_verd != VERD_DROP && idx < reply_len()) begin
      if (mdl_verd == VERD_LED)
        b = (idx < LED_BYTES) ? (st_rd(42 + idx) | LED_MARK) : 8'h00;
      else
        b = st_rd(idx);
    end
    e.kind = r.action;
    e.verdict = mdl_verd;
    e.led_channel = mdl_chan;
    e.length = 12'(reply_len());
    e.truncated = mdl_cut_last;
    e.byte_out = b;
    return 1'b1;
  endfunction

  task automatic report(string field, res_t got, res_t want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_res.size() == 0) begin
        report("unexpected result", res_o, '0);
      end else begin
        want = pending_res.pop_front();
        if (res_o.kind !== want.kind) report("kind", res_o, want);
        if (res_o.verdict !== want.verdict) report("verdict", res_o, want);
        if (res_o.led_channel !== want.led_channel) report("led_channel", res_o, want);
        if (res_o.length !== want.length) report("length", res_o, want);
        if (res_o.truncated !== want.truncated) report("truncated", res_o, want);
        if (res_o.byte_out !== want.byte_out) report("byte_out", res_o, want);
      end
    end
  end

  // issue one request, wait for it to be taken, then maybe idle
  task automatic send(req_t r, bit typed = 1'b0, res_t typed_res = '0);
    res_t e;
    int roll;
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    n_items++;
    if (respond(r, e)) pending_res.push_back(typed ? typed_res : e);
    roll = $urandom_range(0, 99);
    if (roll >= 70) begin
      start <= 1'b0;
      repeat (roll >= 95 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic put_byte(logic [7:0] d, bit last);
    req_t r;
    r.action = 1'b0;
    r.data = d;
    r.last = last;
    r.index = $urandom_range(0, 2047);
    send(r);
  endtask

  task automatic put_read(int idx);
    req_t r;
    r.action = 1'b1;
    r.data = $urandom_range(0, 255);
    r.last = $urandom_range(0, 1);
    r.index = idx;
    send(r);
  endtask

  function automatic void push_n(int n);
    repeat (n) frame_buf.push_back($urandom_range(0, 255));
  endfunction

  function automatic void push_word(logic [31:0] w, int nbytes);
    for (int k = nbytes - 1; k >= 0; k--) frame_buf.push_back(w[8*k +: 8]);
  endfunction

  // builds one frame; mostly well formed, sometimes a field is broken
  function automatic void build_frame(int sel, int len);
    bit ok;
    frame_buf.delete();
    ok = $urandom_range(0, 9) != 0;
    push_word(32'hFFFFFFFF, 4);
    push_word(16'hFFFF, 2);
    push_n(6);
    case (sel)
      0: begin
        push_word(ETH_ARP, 2);
        push_word(32'h00010800, 4);
        push_word(16'h0604, 2);
        push_word(ok ? ARP_REQUEST : $urandom_range(0, 3), 2);
        push_n(10);
        push_word(32'h0, 4);
        push_word(16'h0, 2);
        push_word(ok || $urandom_range(0, 1) ? mdl_ip : $urandom, 4);
      end
      1, 2: begin
        push_word(ETH_IPV4, 2);
        push_word(32'h45000054, 4);
        push_n(4);
        frame_buf.push_back(8'h40);
        frame_buf.push_back(sel == 1 ? (ok ? PROTO_ICMP : PROTO_UDP) : PROTO_UDP);
        push_n(6);
        push_word(ok || sel == 2 ? mdl_ip : $urandom, 4);
        if (sel == 1) begin
          frame_buf.push_back(ok ? ICMP_ECHO : $urandom_range(0, 255));
          frame_buf.push_back(8'h00);
          push_n(2);
        end else begin
          push_n(2);
          push_word(ok ? LED_PORT_LO + $urandom_range(0, 3) :
                    ($urandom_range(0, 1) ? LED_PORT_HI + 1 : LED_PORT_LO - 1), 2);
        end
      end
      default: begin
        push_word($urandom_range(0, 1) ? ETH_IPV4 : $urandom_range(0, 65535), 2);
        push_n(30);
      end
    endcase
    while (frame_buf.size() > len) void'(frame_buf.pop_back());
    while (frame_buf.size() < len) frame_buf.push_back($urandom_range(0, 255));
  endfunction

  task automatic run_frame(int sel, int len);
    int nread;
    build_frame(sel, len);
    foreach (frame_buf[i]) begin
      if ($urandom_range(0, 99) == 0) put_read($urandom_range(0, 2047));
      put_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
    nread = $urandom_range(2, 8);
    repeat (nread) begin
      case ($urandom_range(0, 5))
        0: put_read($urandom_range(0, 2047));
        1: put_read($urandom_range(0, 1) ? LED_BYTES : LED_BYTES + 1);
        default: put_read($urandom_range(0, mdl_verd == VERD_LED ? LED_BYTES : len));
      endcase
    end
  endtask

  task automatic write_regs(logic [31:0] ip, logic [47:0] mac);
    // hold off requests so nothing is in flight while the registers change
    start <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (100) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MY_IP;
    cfg_data_i <= {16'h0, ip};
    @(posedge clk_i);
    cfg_idx_i <= CFG_MY_MAC;
    cfg_data_i <= mac;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_ip = ip;
    mdl_mac = mac;
  endtask

  initial begin
    row_t table_rows [$];
    row_t row;
    int phase;
    int sel;
    foreach (mdl_store[i]) mdl_store[i] = 8'h00;
    mdl_wcount = 0;
    mdl_flen = 0;
    mdl_verd = VERD_DROP;
    mdl_chan = 2'd0;
    mdl_cut_now = 1'b0;
    mdl_cut_last = 1'b0;
    mdl_ip = '0;
    mdl_mac = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reads after reset, then two one byte frames that must drop, then a read
    row.typed = 1'b1;
    row.r = '{action: 1'b1, data: 8'hFF, last: 1'b1, index: 11'd0};
    row.e = '{kind: 1'b1, verdict: VERD_DROP, led_channel: 2'd0, length: 12'd0,
              truncated: 1'b0, byte_out: 8'h00};
    table_rows.push_back(row);
    row.r.index = 11'd2047;
    row.r.data = 8'h00;
    row.r.last = 1'b0;
    table_rows.push_back(row);
    row.r = '{action: 1'b0, data: 8'hFF, last: 1'b1, index: 11'd2047};
    row.e.kind = 1'b0;
    table_rows.push_back(row);
    row.r = '{action: 1'b0, data: 8'h00, last: 1'b1, index: 11'd0};
    table_rows.push_back(row);
    row.typed = 1'b0;
    row.r = '{action: 1'b1, data: 8'h00, last: 1'b0, index: 11'd0};
    table_rows.push_back(row);
    foreach (table_rows[i]) send(table_rows[i].r, table_rows[i].typed, table_rows[i].e);

    write_regs(32'hC0A8_0107, 48'h0200_5E10_2233);
    for (int s = 0; s < 4; s++) run_frame(s, 60);
    run_frame(0, 41);
    run_frame(1, 37);
    run_frame(1, 38);
    run_frame(2, 42);

    phase = 0;
    while (n_items < 1250) begin
      if (n_items > 300 * (phase + 1)) begin
        phase++;
        case (phase % 4)
          0: write_regs(32'h0, 48'h0);
          1: write_regs(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
          default: write_regs($urandom, {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF);
        endcase
        // one oversized frame when phase reaches 2 to hit truncation
        if (phase == 2) run_frame(0, FRAME_BYTES + $urandom_range(1, 20));
      end
      sel = $urandom_range(0, 9);
      sel = sel < 3 ? 0 : sel < 5 ? 1 : sel < 8 ? 2 : 3;
      if ($urandom_range(0, 9) == 0) run_frame(sel, $urandom_range(1, 41));
      else run_frame(sel, $urandom_range(42, 90));
    end

    start <= 1'b0;
    wait (pending_res.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("arp_icmp_udp_frame_responder test passed");
    end else begin
      $display("arp_icmp_udp_frame_responder test failed");
    end
    $finish;
  end

endmodule
